@@ hdl/ifp_pkg.sv @@
// Package for the IMU frame parser: byte codes, frame kinds and the structs
// passed between the parser stages. No dependencies.
`timescale 1ns / 1ps

package ifp_pkg;

  localparam logic [7:0] HDR_BYTE   = 8'h55;
  localparam logic [7:0] TYPE_ACCEL = 8'h51;
  localparam logic [7:0] TYPE_MAG   = 8'h54;

  localparam int unsigned PAYLOAD_BYTES = 8;
  localparam int unsigned IDX_W         = $clog2(PAYLOAD_BYTES);

  // Byte held in the input register, with its valid flag.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } ifp_byte_t;

  // One decoded frame, with the valid flag of the result.
  typedef struct packed {
    logic               valid;
    logic        [1:0]  kind;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic signed [15:0] temp;
  } ifp_result_t;

endpackage

@@ hdl/imu_frame_parser.sv @@
// A frame's checksum byte passes through the input register, and its result is
// then registered in the result register, from which the receiver takes it.
// Throughput: one byte per cycle, set by the single input register feeding the
// frame state machine and the result register behind it. A result stalled by the
// receiver holds every byte back and stalls the input once its register is full.
// Reset: synchronous on rst_n low; parsing starts disabled, the parser hunts for
// a header and both registers are empty.
`timescale 1ns / 1ps

// Top level of the IMU frame parser. Depends on ifp_pkg, ifp_in_stage,
// ifp_assembler and ifp_out_stage.
module imu_frame_parser import ifp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_frame_kind,
  output logic signed [15:0] out_axis_x,
  output logic signed [15:0] out_axis_y,
  output logic signed [15:0] out_axis_z,
  output logic signed [15:0] out_temperature_word
);

  // The input register holds one byte. It is handed to the frame state machine
  // whenever the result register can take whatever that byte produces, which
  // is every cycle unless a finished frame is sitting there stalled.
  ifp_byte_t   held;
  ifp_result_t result;
  ifp_result_t out_q;
  logic        out_ready;
  logic        advance;
  logic        enable;

  assign advance = held.valid && out_ready;

  ifp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .advance    (advance),
    .held       (held)
  );

  // The state machine consumes the held byte on advance. Only the checksum byte
  // of a known frame type yields a result; the checksum itself is not checked.
  // While parsing is disabled every byte is dropped and the hunt restarts.
  ifp_assembler u_asm (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .held      (held),
    .advance   (advance),
    .result    (result),
    .enable    (enable)
  );

  // The result register separates the two sides. While a finished frame waits
  // there for a stalled receiver, no byte leaves the input register, so the
  // input stalls as soon as that register holds a byte.
  ifp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .result    (result),
    .out_stall (out_stall),
    .out_ready (out_ready),
    .out_r_q   (out_q)
  );

  assign out_valid            = out_q.valid;
  assign out_frame_kind       = out_q.kind;
  assign out_axis_x           = out_q.axis_x;
  assign out_axis_y           = out_q.axis_y;
  assign out_axis_z           = out_q.axis_z;
  assign out_temperature_word = out_q.temp;

`ifndef SYNTH
  // A stall toward the sender only comes from a byte stuck in the input register.
  a_stall_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> held.valid)
    else $error("input stalled with an empty input register");

  // A new result only comes from a byte consumed while parsing was enabled.
  a_result_from_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(advance) && $past(enable))
    else $error("result appeared without an enabled byte advancing");

  // A byte never advances into a full, stalled result register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> !advance)
    else $error("byte advanced while the result register was stalled");
`endif

endmodule

@@ hdl/ifp_in_stage.sv @@
// Input register of the IMU frame parser: captures one byte per cycle unless stalled.
// Depends on ifp_pkg.
`timescale 1ns / 1ps

module ifp_in_stage import ifp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       advance,
  output ifp_byte_t  held
);

  logic       valid_r, valid_nxt;
  logic [7:0] data_r;
  logic       load;

  // The register can take a new byte when it is empty or draining this cycle.
  assign load      = !valid_r || advance;
  assign in_stall  = !load;
  assign valid_nxt = load ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      data_r <= in_rx_byte;
    end
  end

  assign held.valid = valid_r;
  assign held.data  = data_r;

endmodule

@@ hdl/ifp_assembler.sv @@
// Frame state machine of the IMU frame parser: hunts for the header, decodes
// the type byte and gathers the payload. Depends on ifp_pkg.
`timescale 1ns / 1ps

module ifp_assembler import ifp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  ifp_byte_t   held,
  input  logic        advance,
  output ifp_result_t result,
  output logic        enable
);

  typedef enum logic [1:0] {
    ST_HUNT,
    ST_TYPE,
    ST_DATA,
    ST_SUM
  } state_t;

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [1:0]        kind_r, kind_nxt;
  logic [7:0]        pay_r [PAYLOAD_BYTES];
  logic              enable_r;
  logic              fire;
  logic              emit;

  assign fire   = advance && held.valid;
  assign enable = enable_r;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    kind_nxt  = kind_r;
    emit      = 1'b0;
    if (fire) begin
      if (!enable_r) begin
        state_nxt = ST_HUNT;
      end else begin
        case (state_r)
          ST_HUNT: begin
            state_nxt = (held.data == HDR_BYTE) ? ST_TYPE : ST_HUNT;
          end
          ST_TYPE: begin
            if (held.data >= TYPE_ACCEL && held.data <= TYPE_MAG) begin
              kind_nxt  = held.data[1:0] - TYPE_ACCEL[1:0];
              idx_nxt   = '0;
              state_nxt = ST_DATA;
            end else begin
              state_nxt = ST_HUNT;
            end
          end
          ST_DATA: begin
            idx_nxt = idx_r + 1'b1;
            if (idx_r == IDX_W'(PAYLOAD_BYTES - 1)) begin
              state_nxt = ST_SUM;
            end
          end
          ST_SUM: begin
            emit      = 1'b1;
            state_nxt = ST_HUNT;
          end
          default: begin
            state_nxt = ST_HUNT;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_HUNT;
      idx_r    <= '0;
      kind_r   <= 2'd0;
      enable_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      kind_r  <= kind_nxt;
      if (cfg_we) begin
        enable_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && enable_r && state_r == ST_DATA) begin
      pay_r[idx_r] <= held.data;
    end
  end

  assign result.valid  = emit;
  assign result.kind   = kind_r;
  assign result.axis_x = {pay_r[1], pay_r[0]};
  assign result.axis_y = {pay_r[3], pay_r[2]};
  assign result.axis_z = {pay_r[5], pay_r[4]};
  assign result.temp   = {pay_r[7], pay_r[6]};

endmodule

@@ hdl/ifp_out_stage.sv @@
// Result register of the IMU frame parser: holds a decoded frame until the
// receiver takes it. Depends on ifp_pkg.
`timescale 1ns / 1ps

module ifp_out_stage import ifp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  ifp_result_t result,
  input  logic        out_stall,
  output logic        out_ready,
  output ifp_result_t out_r_q
);

  logic        valid_r, valid_nxt;
  ifp_result_t data_r;

  assign out_ready = !valid_r || !out_stall;
  assign valid_nxt = out_ready ? result.valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && result.valid) begin
      data_r <= result;
    end
  end

  always_comb begin
    out_r_q       = data_r;
    out_r_q.valid = valid_r;
  end

endmodule

@@ tb/imu_frame_parser_tb.sv @@
// Self-checking testbench for imu_frame_parser: a directed byte script, then random
// frame traffic with sender gaps and receiver stalls, checked against a frame predictor.
// Depends on ifp_pkg and the imu_frame_parser RTL.
`timescale 1ns / 1ps

module imu_frame_parser_tb;
  import ifp_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 4;
  // Covers a byte left in the input register once the results are out, and the rest
  // is margin before a configuration write.
  localparam int DRAIN_CYCLES = 6;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 850;
  localparam int MIN_FRAMES   = 48;

  localparam logic [1:0] KIND_ACCEL = 2'd0;

  // Parser phases: hunt, type byte, eight payload bytes, checksum.
  localparam logic [3:0] PH_HUNT  = 4'd0;
  localparam logic [3:0] PH_TYPE  = 4'd1;
  localparam logic [3:0] PH_DATA0 = 4'd2;
  localparam logic [3:0] PH_SUM   = 4'd10;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic signed [15:0] temp_word;
  } frame_t;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_op_t;

  typedef struct packed {
    row_op_t    op;
    logic [7:0] val;
    logic       typed;
    frame_t     want;
  } script_row_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic               cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         in_rx_byte;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_frame_kind;
  logic signed [15:0] out_axis_x;
  logic signed [15:0] out_axis_y;
  logic signed [15:0] out_axis_z;
  logic signed [15:0] out_temperature_word;

  imu_frame_parser i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_rx_byte           (in_rx_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_frame_kind       (out_frame_kind),
    .out_axis_x           (out_axis_x),
    .out_axis_y           (out_axis_y),
    .out_axis_z           (out_axis_z),
    .out_temperature_word (out_temperature_word)
  );

  always #CLK_HALF clk = ~clk;

  // Predictor state: our own copy of the parser and its enable register.
  logic        parse_en    = 1'b0;
  logic [3:0]  parse_phase = PH_HUNT;
  logic [1:0]  kind_held   = 2'd0;
  logic [63:0] payload     = 64'd0;

  frame_t pending_frames[$];   // frames predicted but not yet seen on the output
  int     faults = 0;
  int     cycles_run = 0;
  int     burst_left = 0;
  int     enabled_items = 0;
  int     frames_predicted = 0;
  bit     long_hold_ask = 1'b0;

  // Advances the predicted parser by one byte. Returns 1 with the finished frame
  // when the byte is a checksum that completes a frame.
  function automatic bit parse_byte(input logic [7:0] b, output frame_t done_frame);
    done_frame = '0;
    if (!parse_en) begin
      // Disabled: the byte is dropped and the hunt restarts, but the kind and
      // payload of a half-gathered frame are kept.
      parse_phase = PH_HUNT;
      return 1'b0;
    end
    if (parse_phase == PH_TYPE) begin
      if (b >= TYPE_ACCEL && b <= TYPE_MAG) begin
        kind_held   = 2'(b - TYPE_ACCEL);
        payload     = 64'd0;
        parse_phase = PH_DATA0;
      end else begin
        // An unknown type, a second header among them, is consumed and never
        // taken as the start of a new frame.
        parse_phase = PH_HUNT;
      end
      return 1'b0;
    end
    if (parse_phase >= PH_DATA0 && parse_phase < PH_SUM) begin
      payload[8 * (parse_phase - PH_DATA0) +: 8] = b;
      parse_phase = parse_phase + 4'd1;
      return 1'b0;
    end
    if (parse_phase == PH_SUM) begin
      // The checksum is not checked: any value completes the frame.
      done_frame.kind      = kind_held;
      done_frame.axis_x    = payload[15:0];
      done_frame.axis_y    = payload[31:16];
      done_frame.axis_z    = payload[47:32];
      done_frame.temp_word = payload[63:48];
      parse_phase = PH_HUNT;
      return 1'b1;
    end
    // Hunting; the unused phase codes behave the same way.
    parse_phase = (b == HDR_BYTE) ? PH_TYPE : PH_HUNT;
    return 1'b0;
  endfunction

  // Offers one byte and waits for it to be taken. The sender runs in bursts: when a
  // burst is used up, valid drops for a random gap before the next one starts.
  // A typed frame, where given, replaces the predicted one as the expectation.
  task automatic send_byte(input logic [7:0] b, input logic typed = 1'b0,
                           input frame_t want = '0);
    frame_t got;
    @(negedge clk);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                : $urandom_range(1, 20);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    // Right after the edge the block's registers still hold their old values,
    // so in_stall here is the value the edge saw.
    do @(posedge clk); while (in_stall);
    burst_left--;
    if (parse_en) enabled_items++;
    if (parse_byte(b, got)) begin
      pending_frames.push_back(typed ? want : got);
      frames_predicted++;
    end
  endtask

  // Stops offering bytes until every predicted frame has come out, then lets the
  // pipeline empty of bytes that produce no result.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_frames.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_enable(input logic value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    parse_en = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Payload bytes lean toward the sign and range extremes of the 16-bit words.
  function automatic logic [7:0] payload_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h7F;
      3:       return 8'h80;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Sends at least n bytes, mostly whole frames of random kind and content, mixed
  // with line noise, headers with a bad type byte and frames cut short.
  task automatic send_stretch(input int n);
    int         sent;
    int         cut;
    logic [7:0] t;
    sent = 0;
    while (sent < n) begin
      case ($urandom_range(0, 9))
        7: begin
          send_byte(($urandom_range(0, 3) == 0) ? HDR_BYTE : 8'($urandom_range(0, 255)));
          sent += 1;
        end
        8: begin
          t = 8'($urandom_range(0, 255));
          if (t >= TYPE_ACCEL && t <= TYPE_MAG) t = HDR_BYTE;
          send_byte(HDR_BYTE);
          send_byte(t);
          sent += 2;
        end
        9: begin
          // A frame broken off early; whatever follows lands in its payload.
          cut = $urandom_range(0, 7);
          send_byte(HDR_BYTE);
          send_byte(8'(TYPE_ACCEL + 8'($urandom_range(0, 3))));
          repeat (cut) send_byte(payload_byte());
          sent += 2 + cut;
        end
        default: begin
          send_byte(HDR_BYTE);
          send_byte(8'(TYPE_ACCEL + 8'($urandom_range(0, 3))));
          repeat (8) send_byte(payload_byte());
          send_byte(8'($urandom_range(0, 255)));
          sent += 11;
        end
      endcase
    end
  endtask

  // Receiver: stalls on segments of random length and style, and holds off for a
  // long stretch when asked, so that results back up into the input.
  int          hold_left = 0;
  int          seg_left = 0;
  stall_mode_t stall_mode = STALL_NONE;

  always @(negedge clk) begin
    if (long_hold_ask) begin
      long_hold_ask = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(4, 40);
        stall_mode = stall_mode_t'($urandom_range(0, 3));
      end
      seg_left--;
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= ~out_stall;
      endcase
    end
  end

  function automatic void check_field(input string name, input logic signed [15:0] want,
                                      input logic signed [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      faults++;
    end
  endfunction

  // Each accepted result is compared with the oldest predicted frame.
  always @(posedge clk) begin
    frame_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_frames.size() == 0) begin
        $error("result with no frame pending: kind %0d x %0d", out_frame_kind, out_axis_x);
        faults++;
      end else begin
        want = pending_frames.pop_front();
        check_field("frame_kind", 16'(want.kind), 16'(out_frame_kind));
        check_field("axis_x", want.axis_x, out_axis_x);
        check_field("axis_y", want.axis_y, out_axis_y);
        check_field("axis_z", want.axis_z, out_axis_z);
        check_field("temperature_word", want.temp_word, out_temperature_word);
      end
    end
  end

  always @(posedge clk) begin
    cycles_run++;
    if (cycles_run > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Directed script: disabled bytes, the hunting and type special cases, and two
  // frames at the ends of the type range with extreme payloads and checksums.
  script_row_t script[$];
  int          stretch_no;

  initial begin
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = 1'b0;
    in_valid   = 1'b0;
    in_rx_byte = 8'h00;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    script = '{
      '{ROW_CFG,  8'h00, 1'b0, '0},
      // Parsing is off: a header and a type byte are simply dropped.
      '{ROW_BYTE, HDR_BYTE, 1'b0, '0},
      '{ROW_BYTE, TYPE_ACCEL, 1'b0, '0},
      '{ROW_CFG,  8'h01, 1'b0, '0},
      // A second header where the type belongs is consumed, and the mag type
      // byte after it is only hunting noise.
      '{ROW_BYTE, HDR_BYTE, 1'b0, '0},
      '{ROW_BYTE, HDR_BYTE, 1'b0, '0},
      '{ROW_BYTE, TYPE_MAG, 1'b0, '0},
      // Type bytes just below and just above the known range.
      '{ROW_BYTE, HDR_BYTE, 1'b0, '0},
      '{ROW_BYTE, TYPE_ACCEL - 8'd1, 1'b0, '0},
      '{ROW_BYTE, HDR_BYTE, 1'b0, '0},
      '{ROW_BYTE, TYPE_MAG + 8'd1, 1'b0, '0},
      // Acceleration frame: most negative, most positive, zero and minus one.
      '{ROW_BYTE, HDR_BYTE, 1'b0, '0},
      '{ROW_BYTE, TYPE_ACCEL, 1'b0, '0},
      '{ROW_BYTE, 8'h00, 1'b0, '0},
      '{ROW_BYTE, 8'h80, 1'b0, '0},
      '{ROW_BYTE, 8'hFF, 1'b0, '0},
      '{ROW_BYTE, 8'h7F, 1'b0, '0},
      '{ROW_BYTE, 8'h00, 1'b0, '0},
      '{ROW_BYTE, 8'h00, 1'b0, '0},
      '{ROW_BYTE, 8'hFF, 1'b0, '0},
      '{ROW_BYTE, 8'hFF, 1'b0, '0},
      '{ROW_BYTE, 8'h00, 1'b1,
        '{KIND_ACCEL, 16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF}},
      // Magnetic field frame with mixed payload and an all-ones checksum.
      '{ROW_BYTE, HDR_BYTE, 1'b0, '0},
      '{ROW_BYTE, TYPE_MAG, 1'b0, '0},
      '{ROW_BYTE, 8'h34, 1'b0, '0},
      '{ROW_BYTE, 8'h12, 1'b0, '0},
      '{ROW_BYTE, 8'hFE, 1'b0, '0},
      '{ROW_BYTE, 8'hFF, 1'b0, '0},
      '{ROW_BYTE, 8'h80, 1'b0, '0},
      '{ROW_BYTE, 8'h00, 1'b0, '0},
      '{ROW_BYTE, 8'h7F, 1'b0, '0},
      '{ROW_BYTE, 8'hFF, 1'b0, '0},
      '{ROW_BYTE, 8'hFF, 1'b0, '0}
    };

    foreach (script[i]) begin
      if (script[i].op == ROW_CFG) begin
        wait_drained();
        write_enable(script[i].val[0]);
      end else begin
        send_byte(script[i].val, script[i].typed, script[i].want);
      end
    end

    // Random part in stretches. Every third stretch runs with parsing off, and the
    // enable is rewritten at quiet points, often in the middle of a frame. In the
    // second stretch the receiver holds off while frames keep coming, so the
    // block fills up and stalls its input.
    enabled_items = 0;
    frames_predicted = 0;
    stretch_no = 0;
    while (enabled_items < RANDOM_ITEMS || frames_predicted < MIN_FRAMES) begin
      wait_drained();
      write_enable(stretch_no % 3 != 2);
      if (stretch_no == 1) long_hold_ask = 1'b1;
      if (stretch_no == 1) send_stretch(200);
      else if (parse_en) send_stretch($urandom_range(40, 150));
      else send_stretch($urandom_range(10, 30));
      stretch_no++;
    end

    wait_drained();
    if (faults == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
